// ===== sv/uvcpfa_pkg.sv =====
package uvcpfa_pkg;

  // Field widths fixed by the packet and result formats
  localparam int HL_W    = 8;
  localparam int FLAGS_W = 8;
  localparam int LEN_W   = 13;
  localparam int FILL_W  = 21;
  localparam int CLEN_W  = 12;
  localparam int ERR_W   = 16;
  localparam int OBUF_W  = 2;

  // Required payload header length
  localparam logic [HL_W-1:0] HDR_LEN = 8'h0c;

  // Flag bit positions in the header flag byte
  localparam int FLAG_FID = 0;
  localparam int FLAG_EOF = 1;
  localparam int FLAG_ERR = 6;

  // Front-to-back queue depth
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Packet class decided by the front end
  typedef enum logic [1:0] {
    CLS_BAD,       // header length byte is wrong
    CLS_SHORT,     // shorter than a header
    CLS_HDR_ONLY,  // header and no payload
    CLS_DATA       // header plus payload
  } cls_t;

  // Classified packet handed from front to back
  typedef struct packed {
    cls_t             cls;
    logic             fid;
    logic             eof;
    logic             err;
    logic             qfull;
    logic [LEN_W-1:0] data_len;
  } item_t;

endpackage

// ===== sv/uvcpfa_in_if.sv =====
interface uvcpfa_in_if;
  logic                          valid;
  logic                          ready;
  logic [uvcpfa_pkg::HL_W-1:0]    header_length_byte;
  logic [uvcpfa_pkg::FLAGS_W-1:0] header_flags;
  logic [uvcpfa_pkg::LEN_W-1:0]   packet_length;
  logic                          queue_full;

  modport source (
    output valid, header_length_byte, header_flags, packet_length, queue_full,
    input  ready
  );
  modport sink (
    input  valid, header_length_byte, header_flags, packet_length, queue_full,
    output ready
  );
endinterface

// ===== sv/uvcpfa_out_if.sv =====
interface uvcpfa_out_if;
  logic                         valid;
  logic                         ready;
  logic                         bad_header;
  logic                         copy_valid;
  logic [uvcpfa_pkg::OBUF_W-1:0] copy_buffer;
  logic [uvcpfa_pkg::FILL_W-1:0] copy_offset;
  logic [uvcpfa_pkg::CLEN_W-1:0] copy_length;
  logic                         frame_done;
  logic [uvcpfa_pkg::OBUF_W-1:0] done_buffer;
  logic [uvcpfa_pkg::FILL_W-1:0] frame_bytes;
  logic [uvcpfa_pkg::ERR_W-1:0]  frame_errors;
  logic                         overflow;
  logic                         dropping;

  modport source (
    output valid, bad_header, copy_valid, copy_buffer, copy_offset, copy_length,
           frame_done, done_buffer, frame_bytes, frame_errors, overflow, dropping,
    input  ready
  );
  modport sink (
    input  valid, bad_header, copy_valid, copy_buffer, copy_offset, copy_length,
           frame_done, done_buffer, frame_bytes, frame_errors, overflow, dropping,
    output ready
  );
endinterface

// ===== sv/uvcpfa_front.sv =====
module uvcpfa_front #(
  parameter int PACKET_BYTES_MAX = 4096
) (
  uvcpfa_in_if.sink           in_ch,
  input  logic                q_ready,
  output logic                q_push,
  output uvcpfa_pkg::item_t   q_item
);

  localparam logic [16:0] PKT_MAX = 17'(PACKET_BYTES_MAX);

  logic [uvcpfa_pkg::LEN_W-1:0] len_c;

  // Clamp over-long packets to the packet size limit
  always_comb begin
    if ({4'b0, in_ch.packet_length} > PKT_MAX) begin
      len_c = PKT_MAX[uvcpfa_pkg::LEN_W-1:0];
    end else begin
      len_c = in_ch.packet_length;
    end
  end

  // Classify the beat and pick out its flags
  always_comb begin
    q_item.fid      = in_ch.header_flags[uvcpfa_pkg::FLAG_FID];
    q_item.eof      = in_ch.header_flags[uvcpfa_pkg::FLAG_EOF];
    q_item.err      = in_ch.header_flags[uvcpfa_pkg::FLAG_ERR];
    q_item.qfull    = in_ch.queue_full;
    q_item.data_len = len_c - uvcpfa_pkg::LEN_W'(uvcpfa_pkg::HDR_LEN);
    if (in_ch.header_length_byte != uvcpfa_pkg::HDR_LEN) begin
      q_item.cls = uvcpfa_pkg::CLS_BAD;
    end else if (len_c < uvcpfa_pkg::LEN_W'(uvcpfa_pkg::HDR_LEN)) begin
      q_item.cls = uvcpfa_pkg::CLS_SHORT;
    end else if (len_c == uvcpfa_pkg::LEN_W'(uvcpfa_pkg::HDR_LEN)) begin
      q_item.cls = uvcpfa_pkg::CLS_HDR_ONLY;
    end else begin
      q_item.cls = uvcpfa_pkg::CLS_DATA;
    end
  end

  assign in_ch.ready = q_ready;
  assign q_push      = in_ch.valid & q_ready;

endmodule

// ===== sv/uvcpfa_queue.sv =====
module uvcpfa_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  uvcpfa_pkg::item_t   push_item,
  output logic                push_ready,
  input  logic                pop,
  output logic                head_valid,
  output uvcpfa_pkg::item_t   head_item
);

  uvcpfa_pkg::item_t                 mem_r [uvcpfa_pkg::QUEUE_DEPTH];
  logic [uvcpfa_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [uvcpfa_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [uvcpfa_pkg::QCNT_W-1:0]     count_r, count_nxt;

  localparam logic [uvcpfa_pkg::QPTR_W-1:0] LAST = uvcpfa_pkg::QPTR_W'(uvcpfa_pkg::QUEUE_DEPTH - 1);
  localparam logic [uvcpfa_pkg::QCNT_W-1:0] FULL = uvcpfa_pkg::QCNT_W'(uvcpfa_pkg::QUEUE_DEPTH);

  assign push_ready = (count_r != FULL);
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== sv/uvcpfa_back.sv =====
module uvcpfa_back #(
  parameter int NUM_BUFFERS     = 4,
  parameter int FRAME_BYTES_MAX = 1048576
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [uvcpfa_pkg::FILL_W-1:0]     cfg_wdata,
  input  logic                              head_valid,
  input  uvcpfa_pkg::item_t                 head_item,
  output logic                              pop,
  uvcpfa_out_if.source                      out_ch
);

  localparam int BUF_W = $clog2(NUM_BUFFERS);
  localparam logic [BUF_W-1:0]  BUF_LAST = BUF_W'(NUM_BUFFERS - 1);
  localparam logic [24:0]       FRM_MAX  = 25'(FRAME_BYTES_MAX);
  localparam int FW = uvcpfa_pkg::FILL_W;
  localparam int EW = uvcpfa_pkg::ERR_W;
  localparam int LW = uvcpfa_pkg::LEN_W;

  // Configuration and frame tracking state
  logic [FW-1:0]    limit_cfg_r;
  logic             prev_fid_r, prev_fid_nxt;
  logic             prev_end_r, prev_end_nxt;
  logic             discard_r, discard_nxt;
  logic             await_r, await_nxt;
  logic [BUF_W-1:0] buf_r, buf_nxt;
  logic [FW-1:0]    fill_r, fill_nxt;
  logic [EW-1:0]    err_cnt_r, err_cnt_nxt;

  // Result register
  logic             out_valid_r;
  logic             bad_r, bad_nxt;
  logic             copy_r, copy_nxt;
  logic [FW-1:0]    copy_off_r, copy_off_nxt;
  logic [uvcpfa_pkg::CLEN_W-1:0] copy_len_r, copy_len_nxt;
  logic             done_r, done_nxt;
  logic [uvcpfa_pkg::OBUF_W-1:0] done_buf_r, done_buf_nxt;
  logic [uvcpfa_pkg::OBUF_W-1:0] copy_buf_r, copy_buf_nxt;
  logic [FW-1:0]    frm_bytes_r, frm_bytes_nxt;
  logic [EW-1:0]    frm_err_r, frm_err_nxt;
  logic             ovf_r, ovf_nxt;

  logic [FW-1:0]    limit;
  logic [FW:0]      sum;
  logic             ovf;
  logic [FW-1:0]    fill_new;
  logic             go;

  assign pop = head_valid & (~out_valid_r | out_ch.ready);

  // Effective frame limit and fill check
  assign limit    = ({4'b0, limit_cfg_r} > FRM_MAX) ? FRM_MAX[FW-1:0] : limit_cfg_r;
  assign sum      = {1'b0, fill_r} + {{(FW + 1 - LW){1'b0}}, head_item.data_len};
  assign ovf      = sum > {1'b0, limit};
  assign fill_new = ovf ? fill_r : sum[FW-1:0];

  // Per-packet frame decision
  always_comb begin
    prev_fid_nxt  = prev_fid_r;
    prev_end_nxt  = prev_end_r;
    discard_nxt   = discard_r;
    await_nxt     = await_r;
    buf_nxt       = buf_r;
    fill_nxt      = fill_r;
    err_cnt_nxt   = err_cnt_r;
    bad_nxt       = 1'b0;
    copy_nxt      = 1'b0;
    copy_buf_nxt  = '0;
    copy_off_nxt  = '0;
    copy_len_nxt  = '0;
    done_nxt      = 1'b0;
    done_buf_nxt  = '0;
    frm_bytes_nxt = '0;
    frm_err_nxt   = '0;
    ovf_nxt       = 1'b0;
    go            = 1'b0;

    case (head_item.cls)
      uvcpfa_pkg::CLS_BAD: begin
        bad_nxt = 1'b1;
      end
      uvcpfa_pkg::CLS_SHORT: begin
        go = 1'b0;
      end
      uvcpfa_pkg::CLS_HDR_ONLY, uvcpfa_pkg::CLS_DATA: begin
        go = 1'b1;
        // header-only packets: seed frame ID, skip if no EOF, else close a discard or end the frame
        if (head_item.cls == uvcpfa_pkg::CLS_HDR_ONLY) begin
          if (await_r) begin
            await_nxt    = 1'b0;
            prev_fid_nxt = ~head_item.fid;
          end
          if (!head_item.eof) begin
            go = 1'b0;
          end else if (discard_r) begin
            prev_fid_nxt = head_item.fid;
            discard_nxt  = 1'b0;
            go           = 1'b0;
          end
        end

        if (go) begin
          if (head_item.err && (err_cnt_r != {EW{1'b1}})) begin
            err_cnt_nxt = err_cnt_r + 1'b1;
          end
          // new frame start: drop it when no buffer, or keep discarding
          if ((head_item.fid != prev_fid_nxt) && prev_end_r) begin
            if (head_item.qfull) begin
              discard_nxt = 1'b1;
              go          = 1'b0;
            end else if (discard_r) begin
              go = 1'b0;
            end
            if (!go && head_item.eof) begin
              prev_fid_nxt = head_item.fid;
              discard_nxt  = 1'b0;
            end
          end
        end

        if (go) begin
          prev_fid_nxt = head_item.fid;
          // payload slice placement
          if (ovf) begin
            ovf_nxt = 1'b1;
          end else if (head_item.data_len != '0) begin
            copy_nxt     = 1'b1;
            copy_buf_nxt = uvcpfa_pkg::OBUF_W'(buf_r);
            copy_off_nxt = fill_r;
            copy_len_nxt = head_item.data_len[uvcpfa_pkg::CLEN_W-1:0];
          end
          fill_nxt = fill_new;
          // end of frame: report and rotate buffer
          if (head_item.eof) begin
            prev_end_nxt  = 1'b1;
            done_nxt      = 1'b1;
            done_buf_nxt  = uvcpfa_pkg::OBUF_W'(buf_r);
            frm_bytes_nxt = fill_new;
            frm_err_nxt   = err_cnt_nxt;
            err_cnt_nxt   = '0;
            fill_nxt      = '0;
            buf_nxt       = (buf_r == BUF_LAST) ? '0 : buf_r + 1'b1;
          end else begin
            prev_end_nxt = 1'b0;
          end
        end
      end
      default: begin
        go = 1'b0;
      end
    endcase
  end

  // Control state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_cfg_r <= FW'(1048576);
      prev_fid_r  <= 1'b0;
      prev_end_r  <= 1'b1;
      discard_r   <= 1'b0;
      await_r     <= 1'b1;
      buf_r       <= '0;
      fill_r      <= '0;
      err_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_cfg_r <= cfg_wdata;
      end
      if (pop) begin
        prev_fid_r <= prev_fid_nxt;
        prev_end_r <= prev_end_nxt;
        discard_r  <= discard_nxt;
        await_r    <= await_nxt;
        buf_r      <= buf_nxt;
        fill_r     <= fill_nxt;
        err_cnt_r  <= err_cnt_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      bad_r       <= bad_nxt;
      copy_r      <= copy_nxt;
      copy_buf_r  <= copy_buf_nxt;
      copy_off_r  <= copy_off_nxt;
      copy_len_r  <= copy_len_nxt;
      done_r      <= done_nxt;
      done_buf_r  <= done_buf_nxt;
      frm_bytes_r <= frm_bytes_nxt;
      frm_err_r   <= frm_err_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.bad_header   = bad_r;
  assign out_ch.copy_valid   = copy_r;
  assign out_ch.copy_buffer  = copy_buf_r;
  assign out_ch.copy_offset  = copy_off_r;
  assign out_ch.copy_length  = copy_len_r;
  assign out_ch.frame_done   = done_r;
  assign out_ch.done_buffer  = done_buf_r;
  assign out_ch.frame_bytes  = frm_bytes_r;
  assign out_ch.frame_errors = frm_err_r;
  assign out_ch.overflow     = ovf_r;
  assign out_ch.dropping     = discard_r;

endmodule

// ===== sv/uvc_payload_frame_assembler.sv =====
// Video payload header deframer. Each input beat describes one isochronous
// packet (header length byte, header flags, packet length, queue-full flag)
// and produces exactly one result beat, which may hold a copy instruction
// (buffer, offset, length) for the payload after the 12-byte header, an
// end-of-frame report (buffer, byte count, saturating error-packet count),
// a reject/overflow indication, or none of them, plus the current discard
// status. A new packet is accepted every cycle while results are taken; the
// front end classifies it combinationally into a two-entry queue, and the
// back end pops the queue head, updates the frame state and loads the result
// register, so a packet passes the queue entry and then the result register
// before its result beat can be taken. When the result side stalls, the
// queue fills and input ready drops until a result is taken. The fill-count
// add and limit compare in the back end are combinational and set that rate.
// frame_limit (cfg_wdata) resets to 1048576 and is capped at
// FRAME_BYTES_MAX; write it only while no packet is in flight.
module uvc_payload_frame_assembler #(
  parameter int NUM_BUFFERS      = 4,
  parameter int FRAME_BYTES_MAX  = 1048576,
  parameter int PACKET_BYTES_MAX = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [uvcpfa_pkg::FILL_W-1:0] cfg_wdata,
  uvcpfa_in_if.sink                     in_ch,
  uvcpfa_out_if.source                  out_ch
);

  logic              q_push;
  logic              q_ready;
  logic              q_pop;
  logic              q_head_valid;
  uvcpfa_pkg::item_t q_item;
  uvcpfa_pkg::item_t q_head;

  uvcpfa_front #(
    .PACKET_BYTES_MAX (PACKET_BYTES_MAX)
  ) u_front (
    .in_ch   (in_ch),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_item  (q_item)
  );

  uvcpfa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item),
    .push_ready (q_ready),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_item  (q_head)
  );

  uvcpfa_back #(
    .NUM_BUFFERS     (NUM_BUFFERS),
    .FRAME_BYTES_MAX (FRAME_BYTES_MAX)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .head_valid (q_head_valid),
    .head_item  (q_head),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

`ifndef SYNTHESIS
  // a slice is never both stored and flagged as overflowing
  a_copy_vs_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.copy_valid && out_ch.overflow))
    else $error("copy and overflow in one beat");

  // a rejected header leaves no other action
  a_bad_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.bad_header) |->
      !(out_ch.copy_valid || out_ch.frame_done || out_ch.overflow))
    else $error("bad header beat carries an action");

  // queue only pops a valid head, and a pop always loads the result register
  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_ch.valid)
    else $error("popped packet produced no result");
`endif

endmodule
